### hdl/lam_pkg.sv
// shared types and constants of the landmark association map
// no dependencies
package lam_pkg;

  localparam int COORD_BITS = 20;
  localparam int RAD_W      = 12;
  localparam int MISS_W     = 4;
  localparam int HIT_W      = 16;
  localparam int COL_W      = 2;
  localparam int SLOT_W     = 6;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEN_W      = HIT_W + 1;
  localparam int NUM_W      = COORD_BITS + HIT_W + 2;

  localparam logic CMD_OBS   = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OBS  = 2'd2;

  localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  typedef struct packed {
    logic                         command;
    logic signed [COORD_BITS-1:0] obs_x;
    logic signed [COORD_BITS-1:0] obs_y;
    logic [COL_W-1:0]             obs_colour;
  } lam_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]            result_kind;
    logic [SLOT_W-1:0]            slot_index;
    logic                         new_entry;
    logic                         table_full;
    logic signed [COORD_BITS-1:0] cone_x;
    logic signed [COORD_BITS-1:0] cone_y;
    logic [COL_W-1:0]             cone_colour;
    logic [HIT_W-1:0]             hit_count;
    logic                         last;
  } lam_res_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [HIT_W-1:0]             hits;
    logic [MISS_W-1:0]            misses;
    logic [COL_W-1:0]             colour;
  } lam_entry_t;

  typedef struct packed {
    logic [RAD_W-1:0]  match_radius;
    logic [MISS_W-1:0] miss_limit;
    logic [HIT_W-1:0]  hit_floor;
  } lam_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_MERGE, ST_DECIDE,
    ST_PRUNE, ST_FLUSH
  } lam_state_e;

endpackage

### hdl/landmark_association_map.sv
// top level of the landmark association map: front queue and back sequencer
// depends on lam_pkg, lam_front, lam_back
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+------------------------------
//  request   | req_i                               | taken when start & !busy
//  result    | res_o                               | res_valid_o for one cycle
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i    | written when cfg_we_i
//
// an observation without a match scans every table entry; a match at slot i ends
// the scan after i+1 entries and adds the multiply and a 38-step bit-serial
// divide. a frame end passes one table entry a cycle through the single memory
// read port. up to two requests queue ahead of the sequencer; busy rises when
// both are held. reset empties the table at once; results cannot be held off.
module landmark_association_map #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lam_pkg::lam_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [lam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lam_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic              res_valid_o,
  output lam_pkg::lam_res_t res_o
);
  import lam_pkg::*;

  logic     q_valid, q_pop;
  lam_req_t q_item;
  lam_cfg_t cfg;

  lam_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .cfg_o       (cfg)
  );

  lam_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .cfg_i       (cfg),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

### hdl/lam_front.sv
// front end: request queue of two and the configuration registers
// depends on lam_pkg
module lam_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lam_pkg::lam_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [lam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lam_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic              pop_i,
  output logic              valid_o,
  output lam_pkg::lam_req_t item_o,
  output lam_pkg::lam_cfg_t cfg_o
);
  import lam_pkg::*;

  lam_req_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;
  lam_cfg_t   cfg_q;

  assign busy    = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign push    = start & ~busy;
  assign pop     = pop_i & valid_o;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_radius <= RAD_W'(192);
      cfg_q.miss_limit   <= MISS_W'(5);
      cfg_q.hit_floor    <= HIT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS:   cfg_q.match_radius <= cfg_wdata_i[RAD_W-1:0];
        CFG_MAX_MISS: cfg_q.miss_limit   <= cfg_wdata_i[MISS_W-1:0];
        CFG_MIN_OBS:  cfg_q.hit_floor    <= cfg_wdata_i[HIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/lam_div.sv
// bit-serial signed divider, two lanes sharing one step counter
// depends on lam_pkg
module lam_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [lam_pkg::NUM_W-1:0] num_x_i,
  input  logic signed [lam_pkg::NUM_W-1:0] num_y_i,
  input  logic [lam_pkg::DEN_W-1:0]        den_i,
  output logic done_o,
  output logic signed [lam_pkg::COORD_BITS-1:0] q_x_o,
  output logic signed [lam_pkg::COORD_BITS-1:0] q_y_o
);
  import lam_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag_q [2];
  logic [DEN_W-1:0] rem_q [2];
  logic             neg_q [2];
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [NUM_W-1:0] mag_d [2];
  logic [DEN_W-1:0] rem_d [2];
  logic [DEN_W:0]   trial [2];
  logic [NUM_W-1:0] qv [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], mag_q[l][NUM_W-1]};
      if (trial[l] >= {1'b0, den_q}) begin
        rem_d[l] = DEN_W'(trial[l] - {1'b0, den_q});
        mag_d[l] = {mag_q[l][NUM_W-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[l][DEN_W-1:0];
        mag_d[l] = {mag_q[l][NUM_W-2:0], 1'b0};
      end
      qv[l] = neg_q[l] ? (~mag_q[l] + NUM_W'(1)) : mag_q[l];
    end
  end

  assign done_o = done_q;
  assign q_x_o  = qv[0][COORD_BITS-1:0];
  assign q_y_o  = qv[1][COORD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q[0] <= num_x_i[NUM_W-1] ? NUM_W'(-num_x_i) : NUM_W'(num_x_i);
      mag_q[1] <= num_y_i[NUM_W-1] ? NUM_W'(-num_y_i) : NUM_W'(num_y_i);
      neg_q[0] <= num_x_i[NUM_W-1];
      neg_q[1] <= num_y_i[NUM_W-1];
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      den_q    <= den_i;
    end else if (run_q) begin
      mag_q[0] <= mag_d[0];
      mag_q[1] <= mag_d[1];
      rem_q[0] <= rem_d[0];
      rem_q[1] <= rem_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/lam_back.sv
// back end: entry table memory, association scan, merge and frame-end pass
// depends on lam_pkg and lam_div
module lam_back #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  lam_pkg::lam_req_t item_i,
  output logic              pop_o,
  input  lam_pkg::lam_cfg_t cfg_i,
  output logic              res_valid_o,
  output lam_pkg::lam_res_t res_o
);
  import lam_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  lam_state_e state_q, state_d;
  lam_req_t   item_q, item_d;
  logic [CNT_W-1:0] ridx_q, ridx_d, count_q, count_d, keep_q, keep_d;
  logic [IDX_W-1:0] cidx_q, cidx_d, hit_idx_q, hit_idx_d;
  lam_entry_t ent_q, ent_d;
  logic signed [NUM_W-1:0] numx_q, numx_d, numy_q, numy_d;
  logic [DEN_W-1:0] den_q, den_d;
  lam_res_t pend_q, pend_d, res_q, res_d;
  logic     pend_vld_q, pend_vld_d, res_vld_q, res_vld_d;

  lam_entry_t mem_q [MAX_ENTRIES];
  lam_entry_t rdata_q, wr_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic rd_en, we;

  logic div_start, div_done;
  logic signed [COORD_BITS-1:0] qx, qy;

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        adx, ady;
  logic [2*RAD_W-1:0]         sqx, sqy, rr;
  logic [2*RAD_W:0]           dsq;
  logic                       near, match;
  logic [HIT_W-1:0]           hits_inc;
  logic signed [COORD_BITS+HIT_W:0] prodx, prody;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  lam_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_x_i (numx_q),
    .num_y_i (numy_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .q_x_o   (qx),
    .q_y_o   (qy)
  );

  // distance test against the entry read last cycle
  always_comb begin
    dx   = {rdata_q.x[COORD_BITS-1], rdata_q.x} - {item_q.obs_x[COORD_BITS-1], item_q.obs_x};
    dy   = {rdata_q.y[COORD_BITS-1], rdata_q.y} - {item_q.obs_y[COORD_BITS-1], item_q.obs_y};
    adx  = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    ady  = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    sqx  = adx[RAD_W-1:0] * adx[RAD_W-1:0];
    sqy  = ady[RAD_W-1:0] * ady[RAD_W-1:0];
    rr   = cfg_i.match_radius * cfg_i.match_radius;
    dsq  = {1'b0, sqx} + {1'b0, sqy};
    near = (adx < (COORD_BITS+1)'(cfg_i.match_radius)) &&
           (ady < (COORD_BITS+1)'(cfg_i.match_radius)) && (dsq < {1'b0, rr});
    match = near && (rdata_q.colour == item_q.obs_colour);
    hits_inc = (ent_q.hits == HIT_MAX) ? ent_q.hits : ent_q.hits + HIT_W'(1);
    prodx = ent_q.x * $signed({1'b0, ent_q.hits});
    prody = ent_q.y * $signed({1'b0, ent_q.hits});
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    ridx_d     = ridx_q;
    count_d    = count_q;
    keep_d     = keep_q;
    cidx_d     = cidx_q;
    hit_idx_d  = hit_idx_q;
    ent_d      = ent_q;
    numx_d     = numx_q;
    numy_d     = numy_q;
    den_d      = den_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = ridx_q[IDX_W-1:0];
    we         = 1'b0;
    wr_addr    = keep_q[IDX_W-1:0];
    wr_data    = rdata_q;
    div_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          pop_o      = 1'b1;
          item_d     = item_i;
          keep_d     = '0;
          pend_vld_d = 1'b0;
          if (count_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            cidx_d  = '0;
            ridx_d  = CNT_W'(1);
            state_d = (item_i.command == CMD_OBS) ? ST_SCAN : ST_PRUNE;
          end else begin
            state_d = (item_i.command == CMD_OBS) ? ST_DECIDE : ST_FLUSH;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          hit_idx_d = cidx_q;
          ent_d     = rdata_q;
          state_d   = ST_MUL;
        end else if (ridx_q < count_q) begin
          rd_en  = 1'b1;
          cidx_d = ridx_q[IDX_W-1:0];
          ridx_d = ridx_q + CNT_W'(1);
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_MUL: begin
        numx_d  = NUM_W'(prodx) + NUM_W'(item_q.obs_x);
        numy_d  = NUM_W'(prody) + NUM_W'(item_q.obs_y);
        den_d   = {1'b0, ent_q.hits} + DEN_W'(1);
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        we             = 1'b1;
        wr_addr        = hit_idx_q;
        wr_data.x      = qx;
        wr_data.y      = qy;
        wr_data.hits   = hits_inc;
        wr_data.misses = '0;
        wr_data.colour = ent_q.colour;
        res_vld_d         = 1'b1;
        res_d.result_kind = KIND_REPORT;
        res_d.slot_index  = SLOT_W'(hit_idx_q);
        res_d.new_entry   = 1'b0;
        res_d.table_full  = 1'b0;
        res_d.cone_x      = qx;
        res_d.cone_y      = qy;
        res_d.cone_colour = item_q.obs_colour;
        res_d.hit_count   = hits_inc;
        res_d.last        = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_DECIDE: begin
        res_vld_d         = 1'b1;
        res_d.result_kind = KIND_REPORT;
        res_d.cone_x      = item_q.obs_x;
        res_d.cone_y      = item_q.obs_y;
        res_d.cone_colour = item_q.obs_colour;
        res_d.last        = 1'b1;
        if (count_q < CNT_W'(MAX_ENTRIES)) begin
          we             = 1'b1;
          wr_addr        = count_q[IDX_W-1:0];
          wr_data.x      = item_q.obs_x;
          wr_data.y      = item_q.obs_y;
          wr_data.hits   = HIT_W'(1);
          wr_data.misses = '0;
          wr_data.colour = item_q.obs_colour;
          count_d        = count_q + CNT_W'(1);
          res_d.slot_index = SLOT_W'(count_q);
          res_d.new_entry  = 1'b1;
          res_d.table_full = 1'b0;
          res_d.hit_count  = HIT_W'(1);
        end else begin
          res_d.slot_index = '0;
          res_d.new_entry  = 1'b0;
          res_d.table_full = 1'b1;
          res_d.hit_count  = '0;
        end
        state_d = ST_IDLE;
      end
      ST_PRUNE: begin
        // survivors move down to keep_q, aged on the way; a found entry is
        // held back one step so the final one can carry last
        if (rdata_q.misses <= cfg_i.miss_limit) begin
          we             = 1'b1;
          wr_data.misses = (rdata_q.misses == MISS_MAX) ? rdata_q.misses
                                                        : rdata_q.misses + MISS_W'(1);
          keep_d         = keep_q + CNT_W'(1);
          if (rdata_q.hits >= cfg_i.hit_floor) begin
            if (pend_vld_q) begin
              res_vld_d = 1'b1;
              res_d     = pend_q;
            end
            pend_d.result_kind = KIND_ENTRY;
            pend_d.slot_index  = SLOT_W'(keep_q);
            pend_d.new_entry   = 1'b0;
            pend_d.table_full  = 1'b0;
            pend_d.cone_x      = rdata_q.x;
            pend_d.cone_y      = rdata_q.y;
            pend_d.cone_colour = rdata_q.colour;
            pend_d.hit_count   = rdata_q.hits;
            pend_d.last        = 1'b0;
            pend_vld_d         = 1'b1;
          end
        end
        if (ridx_q < count_q) begin
          rd_en  = 1'b1;
          ridx_d = ridx_q + CNT_W'(1);
        end else begin
          count_d = keep_d;
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        res_vld_d = 1'b1;
        if (pend_vld_q) begin
          res_d      = pend_q;
          res_d.last = 1'b1;
        end else begin
          res_d             = '0;
          res_d.result_kind = KIND_EMPTY;
          res_d.last        = 1'b1;
        end
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    ridx_q    <= ridx_d;
    keep_q    <= keep_d;
    cidx_q    <= cidx_d;
    hit_idx_q <= hit_idx_d;
    ent_q     <= ent_d;
    numx_q    <= numx_d;
    numy_q    <= numy_d;
    den_q     <= den_d;
    pend_q    <= pend_d;
    res_q     <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
